FILE: design/dta_pkg.sv
// Shared constants, types and helpers for the descriptor table allocator.
package dta_pkg;

    localparam int FREE_DEPTH = 64;
    localparam int HEAP_KINDS = 3;

    localparam int LIST_DEPTH = HEAP_KINDS * FREE_DEPTH;
    localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int IDX_W      = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FREE_DEPTH + 1);
    localparam int HEAP_W     = (HEAP_KINDS > 1) ? $clog2(HEAP_KINDS) : 1;

    // base and stride slots, one per code of the heap field
    localparam int CFG_HEAPS = 4;

    localparam logic [15:0] CAP_RESET    = 16'd20000;
    localparam logic [12:0] STRIDE_RESET = 13'd32;

    localparam logic [2:0] CFG_BASE_VIEW      = 3'd0;
    localparam logic [2:0] CFG_BASE_SAMPLER   = 3'd1;
    localparam logic [2:0] CFG_BASE_TARGET    = 3'd2;
    localparam logic [2:0] CFG_STRIDE_VIEW    = 3'd3;
    localparam logic [2:0] CFG_STRIDE_SAMPLER = 3'd4;
    localparam logic [2:0] CFG_STRIDE_TARGET  = 3'd5;
    localparam logic [2:0] CFG_HEAP_CAPACITY  = 3'd6;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] STAT_FRESH   = 3'd0;
    localparam logic [2:0] STAT_REUSED  = 3'd1;
    localparam logic [2:0] STAT_FREED   = 3'd2;
    localparam logic [2:0] STAT_NO_ROOM = 3'd3;
    localparam logic [2:0] STAT_ZERO    = 3'd4;
    localparam logic [2:0] STAT_FULL    = 3'd5;

    typedef struct packed {
        logic [15:0] index;
        logic [15:0] length;
        logic [31:0] tag;
    } t_entry;

    typedef struct packed {
        logic               en;
        logic [LIST_AW-1:0] addr;
        t_entry             data;
    } t_ram_wr;

    // row of a heap's free list inside the shared list memory
    function automatic logic [LIST_AW-1:0] list_addr(input logic [1:0] heap,
                                                     input logic [FILL_W-1:0] pos);
        return LIST_AW'(32'(heap) * FREE_DEPTH + 32'(pos));
    endfunction

endpackage

FILE: design/descriptor_table_allocator.sv
// Top level: request sequencer, heap state, configuration and result register.
//
//   channel   direction  handshake            payload
//   request   in         i_valid / o_stall    i_op i_heap_sel i_run_length i_free_index i_free_tag
//   result    out        o_valid / i_stall    o_status o_heap_out o_slot_index o_slot_address
//                                             o_run_out o_tag_out
//   config    in         i_cfg_we             i_cfg_idx i_cfg_data
//
// A free or an early error goes straight to the result step. An allocation scans the
// heap's free list: a hit moves the last entry into the hole, and after a scan of up
// to 64 entries without a hit a fresh run is taken from the heap or refused. The scan
// reads one free list entry per cycle from the list memory's single read port.
// Reset is synchronous; the list memory is not cleared.
// The block takes a new request as soon as the previous result sits in the
// output register; a stalled output holds the sequencer in its final step.
module descriptor_table_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [1:0]  i_heap_sel,
    input  logic [15:0] i_run_length,
    input  logic [15:0] i_free_index,
    input  logic [31:0] i_free_tag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [1:0]  o_heap_out,
    output logic [15:0] o_slot_index,
    output logic [47:0] o_slot_address,
    output logic [15:0] o_run_out,
    output logic [31:0] o_tag_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);
    import dta_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MOVE  = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_ADD   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]        r_state;
    logic              r_op;
    logic [1:0]        r_heap;
    logic [15:0]       r_len;
    logic [15:0]       r_fidx;
    logic [31:0]       r_ftag;
    logic [IDX_W-1:0]  r_scan;
    logic [IDX_W-1:0]  r_hit_pos;
    logic [FILL_W-1:0] r_last;

    logic [47:0]       r_base   [CFG_HEAPS];
    logic [12:0]       r_stride [CFG_HEAPS];
    logic [15:0]       r_cap;

    logic [15:0]       r_next [HEAP_KINDS];
    logic [FILL_W-1:0] r_fill [HEAP_KINDS];
    logic [31:0]       r_tag_cnt;

    logic [2:0]        r_res_status;
    logic [1:0]        r_res_heap;
    logic [15:0]       r_res_idx;
    logic [15:0]       r_res_len;
    logic [31:0]       r_res_tag;
    logic              r_res_use_addr;

    logic              r_out_valid;
    logic [2:0]        r_out_status;
    logic [1:0]        r_out_heap;
    logic [15:0]       r_out_idx;
    logic [47:0]       r_out_addr;
    logic [15:0]       r_out_len;
    logic [31:0]       r_out_tag;

    logic              w_heap_ok;
    logic [HEAP_W-1:0] w_hsel;
    logic [FILL_W-1:0] w_fill;
    logic [15:0]       w_next;
    logic [15:0]       w_room;
    logic              w_hit;
    logic              w_scan_end;
    logic              w_load;
    logic [47:0]       w_addr;

    t_ram_wr           ram_wr;
    logic              rd_en;
    logic [LIST_AW-1:0] rd_addr;
    t_entry            rd_data;

    dta_list_ram u_list (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    dta_addr_calc u_addr (
        .i_clk    (i_clk),
        .i_base   (r_base[r_heap]),
        .i_stride (r_stride[r_heap]),
        .i_index  (r_res_idx),
        .o_addr   (w_addr)
    );

    assign o_stall = (r_state != ST_IDLE);
    assign w_load  = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        w_heap_ok  = {1'b0, r_heap} < 3'(HEAP_KINDS);
        w_hsel     = r_heap[HEAP_W-1:0];
        w_fill     = r_fill[w_hsel];
        w_next     = r_next[w_hsel];
        w_room     = (w_next < r_cap) ? (r_cap - w_next) : 16'd0;
        w_hit      = (rd_data.length == r_len);
        w_scan_end = (FILL_W'(r_scan) == r_last);
        ram_wr     = '0;
        rd_en      = 1'b0;
        rd_addr    = list_addr(r_heap, '0);
        case (r_state)
            ST_CHECK: begin
                if (r_op == OP_FREE && w_heap_ok && w_fill < FILL_W'(FREE_DEPTH)) begin
                    ram_wr.en          = 1'b1;
                    ram_wr.addr        = list_addr(r_heap, w_fill);
                    ram_wr.data.index  = r_fidx;
                    ram_wr.data.length = r_len;
                    ram_wr.data.tag    = r_ftag;
                end
                // fetch the first entry ahead of the scan
                rd_en = (r_op == OP_ALLOC) && w_heap_ok;
            end
            ST_SCAN: begin
                if (w_hit) begin
                    rd_en   = 1'b1;
                    rd_addr = list_addr(r_heap, r_last);
                end else if (!w_scan_end) begin
                    rd_en   = 1'b1;
                    rd_addr = list_addr(r_heap, FILL_W'(r_scan) + FILL_W'(1));
                end
            end
            ST_MOVE: begin
                // move the last entry into the hole
                ram_wr.en   = 1'b1;
                ram_wr.addr = list_addr(r_heap, FILL_W'(r_hit_pos));
                ram_wr.data = rd_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_op           <= OP_ALLOC;
            r_heap         <= '0;
            r_len          <= '0;
            r_fidx         <= '0;
            r_ftag         <= '0;
            r_scan         <= '0;
            r_hit_pos      <= '0;
            r_last         <= '0;
            r_cap          <= CAP_RESET;
            r_tag_cnt      <= 32'd1;
            r_res_status   <= STAT_FRESH;
            r_res_heap     <= '0;
            r_res_idx      <= '0;
            r_res_len      <= '0;
            r_res_tag      <= '0;
            r_res_use_addr <= 1'b0;
            for (int h = 0; h < CFG_HEAPS; h++) begin
                r_base[h]   <= '0;
                r_stride[h] <= STRIDE_RESET;
            end
            for (int h = 0; h < HEAP_KINDS; h++) begin
                r_next[h] <= '0;
                r_fill[h] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_VIEW:      r_base[0]   <= i_cfg_data;
                    CFG_BASE_SAMPLER:   r_base[1]   <= i_cfg_data;
                    CFG_BASE_TARGET:    r_base[2]   <= i_cfg_data;
                    CFG_STRIDE_VIEW:    r_stride[0] <= i_cfg_data[12:0];
                    CFG_STRIDE_SAMPLER: r_stride[1] <= i_cfg_data[12:0];
                    CFG_STRIDE_TARGET:  r_stride[2] <= i_cfg_data[12:0];
                    CFG_HEAP_CAPACITY:  r_cap       <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_heap  <= i_heap_sel;
                        r_len   <= i_run_length;
                        r_fidx  <= i_free_index;
                        r_ftag  <= i_free_tag;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_res_heap     <= w_heap_ok ? r_heap : 2'd0;
                    r_res_idx      <= '0;
                    r_res_len      <= '0;
                    r_res_tag      <= '0;
                    r_res_use_addr <= 1'b0;
                    r_scan         <= '0;
                    r_last         <= w_fill - FILL_W'(1);
                    r_state        <= ST_DONE;
                    if (r_op == OP_FREE) begin
                        if (!w_heap_ok || w_fill >= FILL_W'(FREE_DEPTH)) begin
                            r_res_status <= STAT_FULL;
                        end else begin
                            r_res_status   <= STAT_FREED;
                            r_fill[w_hsel] <= w_fill + FILL_W'(1);
                        end
                    end else if (r_len == 16'd0) begin
                        r_res_status <= STAT_ZERO;
                    end else if (!w_heap_ok) begin
                        r_res_status <= STAT_NO_ROOM;
                    end else if (w_fill == '0) begin
                        r_state <= ST_MISS;
                    end else begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_hit) begin
                        r_res_status <= STAT_REUSED;
                        r_res_idx    <= rd_data.index;
                        r_res_tag    <= rd_data.tag;
                        r_res_len    <= r_len;
                        r_hit_pos    <= r_scan;
                        r_state      <= ST_MOVE;
                    end else if (w_scan_end) begin
                        r_state <= ST_MISS;
                    end else begin
                        r_scan <= r_scan + IDX_W'(1);
                    end
                end
                ST_MOVE: begin
                    r_fill[w_hsel] <= r_last;
                    r_res_use_addr <= 1'b1;
                    r_state        <= ST_MUL;
                end
                ST_MISS: begin
                    if (r_len > w_room) begin
                        r_res_status <= STAT_NO_ROOM;
                        r_state      <= ST_DONE;
                    end else begin
                        r_res_status   <= STAT_FRESH;
                        r_res_idx      <= w_next;
                        r_res_len      <= r_len;
                        r_res_tag      <= r_tag_cnt;
                        r_res_use_addr <= 1'b1;
                        r_tag_cnt      <= r_tag_cnt + 32'd1;
                        r_next[w_hsel] <= w_next + r_len;
                        r_state        <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // result register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_res_status;
            r_out_heap   <= r_res_heap;
            r_out_idx    <= r_res_idx;
            r_out_addr   <= r_res_use_addr ? w_addr : 48'd0;
            r_out_len    <= r_res_len;
            r_out_tag    <= r_res_tag;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_heap_out     = r_out_heap;
    assign o_slot_index   = r_out_idx;
    assign o_slot_address = r_out_addr;
    assign o_run_out      = r_out_len;
    assign o_tag_out      = r_out_tag;

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("result loaded outside the final step");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_wr.en |-> (r_state == ST_CHECK || r_state == ST_MOVE))
        else $error("list write outside push or move");

    a_tag_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_tag_cnt) |-> $past(r_state) == ST_MISS)
        else $error("tag counter moved without a fresh allocation");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (FILL_W'(r_scan) <= r_last))
        else $error("scan ran past the last free list entry");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[0] <= FILL_W'(FREE_DEPTH))
        else $error("free list fill above its depth");

endmodule

FILE: design/dta_list_ram.sv
// Free list storage for all heaps: one write port, one registered read port.
module dta_list_ram (
    input  logic                          i_clk,
    input  dta_pkg::t_ram_wr              i_wr,
    input  logic                          i_rd_en,
    input  logic [dta_pkg::LIST_AW-1:0]   i_rd_addr,
    output dta_pkg::t_entry               o_rd_data
);
    import dta_pkg::*;

    t_entry r_mem [LIST_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/dta_addr_calc.sv
// Slot address unit: stride times index, then plus base, one register each.
module dta_addr_calc (
    input  logic        i_clk,
    input  logic [47:0] i_base,
    input  logic [12:0] i_stride,
    input  logic [15:0] i_index,
    output logic [47:0] o_addr
);
    import dta_pkg::*;

    logic [28:0] r_prod;
    logic [47:0] r_addr;

    always_ff @(posedge i_clk) begin
        r_prod <= 29'(i_stride) * 29'(i_index);
        r_addr <= i_base + {19'd0, r_prod};
    end

    assign o_addr = r_addr;

endmodule
